>>> design/cpu_bus_decoder_with_joypad_ports_unit_macros.svh
// Assertion macros used by the CPU bus decoder top-level design file.
// Depends on nothing; the using module must have clock and reset signals.
`ifndef CPU_BUS_DECODER_WITH_JOYPAD_PORTS_UNIT_MACROS_SVH
`define CPU_BUS_DECODER_WITH_JOYPAD_PORTS_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CBD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/cbd_pkg.sv
// Types and constants for the CPU bus decoder with joypad ports.
// Used by every module of the block but cbd_ram; depends on nothing.
package cbd_pkg;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_BUTTON = 2'd2
   } op_type;

   // Bus targets reported with each result item.
   typedef enum logic [2:0] {
      TGT_RAM    = 3'd0,
      TGT_PIC    = 3'd1,
      TGT_AUDIO  = 3'd2,
      TGT_PAD    = 3'd3,
      TGT_DMA    = 3'd4,
      TGT_CART   = 3'd5,
      TGT_MAPPER = 3'd6,
      TGT_NONE   = 3'd7
   } target_type;

   // Address map.
   localparam logic [15:0] ADDR_RAM_WINDOW = 16'h1FFF;
   localparam logic [15:0] ADDR_PIC_BASE   = 16'h2000;
   localparam logic [15:0] ADDR_PIC_LAST   = 16'h3FFF;
   localparam logic [15:0] ADDR_PIC_MASK   = 16'h0007;
   localparam logic [15:0] ADDR_DMA        = 16'h4014;
   localparam logic [15:0] ADDR_PAD0       = 16'h4016;
   localparam logic [15:0] ADDR_PAD1       = 16'h4017;
   localparam logic [15:0] ADDR_CART       = 16'h6000;
   localparam logic [15:0] ADDR_MAPPER     = 16'h8000;

   // Bit that floats high on a serial joypad read.
   localparam logic [7:0] PAD_OPEN_BUS = 8'h40;

   // Input item.
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        pad_port;
      logic [2:0]  button_bit;
      logic        pressed;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [7:0]  read_data;
      logic        served_inside;
      target_type  target;
      logic [15:0] forward_address;
   } rsp_type;

   // Decoded access, from the decoder to the top level.
   typedef struct packed {
      target_type  target;
      logic        served;
      logic        ram_wr;
      logic        ram_rd;
      logic        pad_rd;
      logic        strobe_wr;
      logic [15:0] fwd;
   } dec_type;

   // Joypad port controls, already qualified by item acceptance.
   typedef struct packed {
      logic       btn_en;
      logic       rd_en;
      logic       strobe_wr;
      logic       strobe_data;
      logic       port;
      logic [2:0] button_bit;
      logic       pressed;
   } pad_ctl_type;

endpackage

>>> design/cpu_bus_decoder_with_joypad_ports_unit.sv
// CPU bus decoder with work RAM and two joypad ports: one access per item and
// exactly one result item per input item. An item is taken in every cycle in
// which the result register is empty or being emptied, and its result appears
// in the cycle after acceptance; the throughput of one item per cycle is set by
// the single registered pass through the decoder, the RAM port and the
// joypad logic. The work RAM is not cleared at reset, so a read of a RAM byte
// that was never written returns an undefined value.
// Depends on cbd_pkg, cbd_decode, cbd_ram, cbd_pads and the assertion macros.
`include "cpu_bus_decoder_with_joypad_ports_unit_macros.svh"

module cpu_bus_decoder_with_joypad_ports_unit #(
   parameter int RAM_DEPTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbd_pkg::rsp_type rsp_payload
);

   localparam int IdxW = $clog2(RAM_DEPTH);

   logic                 accept;
   cbd_pkg::dec_type     dec;
   cbd_pkg::pad_ctl_type pad_ctl;
   logic [7:0]           pad_rd_data;
   logic [7:0]           ram_rd_data;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   cbd_pkg::target_type  target_ff;
   logic                 served_ff;
   logic [15:0]          fwd_ff;
   logic                 ram_sel_ff;
   logic [7:0]           pad_data_ff;
   logic [7:0]           pad_data_in;

   // Input handshake: take an item whenever the result register can move.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   cbd_decode #(
      .RAM_DEPTH(RAM_DEPTH)
   ) u_decode (
      .req(req_payload),
      .dec(dec)
   );

   cbd_ram #(
      .RAM_DEPTH(RAM_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (accept && dec.ram_wr),
      .rd_en  (accept && dec.ram_rd),
      .addr   (dec.fwd[IdxW-1:0]),
      .wr_data(req_payload.write_data),
      .rd_data(ram_rd_data)
   );

   // Joypad controls, qualified by acceptance of the item.
   always_comb begin
      pad_ctl.btn_en      = accept && (req_payload.op == cbd_pkg::OP_BUTTON);
      pad_ctl.rd_en       = accept && dec.pad_rd;
      pad_ctl.strobe_wr   = accept && dec.strobe_wr;
      pad_ctl.strobe_data = req_payload.write_data[0];
      pad_ctl.port        = (req_payload.op == cbd_pkg::OP_BUTTON) ?
                            req_payload.pad_port : req_payload.address[0];
      pad_ctl.button_bit  = req_payload.button_bit;
      pad_ctl.pressed     = req_payload.pressed;
   end

   cbd_pads u_pads (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pad_ctl),
      .rd_data(pad_rd_data)
   );

   // Result register control.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      pad_data_in = dec.pad_rd ? pad_rd_data : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; RAM read data arrives from the RAM's own output register.
   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff   <= dec.target;
         served_ff   <= dec.served;
         fwd_ff      <= dec.fwd;
         ram_sel_ff  <= dec.ram_rd;
         pad_data_ff <= pad_data_in;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_payload.read_data       = ram_sel_ff ? ram_rd_data : pad_data_ff;
   assign rsp_payload.served_inside   = served_ff;
   assign rsp_payload.target          = target_ff;
   assign rsp_payload.forward_address = fwd_ff;

   // Only RAM and joypad accesses are served inside.
   `CBD_ASSERT_NOW(a_served_target, rsp_valid_ff && served_ff, (target_ff == cbd_pkg::TGT_RAM) || (target_ff == cbd_pkg::TGT_PAD), "served item with a target that is not served inside")
   // Accesses not served inside return no data.
   `CBD_ASSERT_NOW(a_unserved_zero, rsp_valid_ff && !served_ff, rsp_payload.read_data == 8'h00, "unserved item returned nonzero data")
   // A button event yields an empty result in the next cycle.
   `CBD_ASSERT_NEXT(a_button_result, accept && (req_payload.op == cbd_pkg::OP_BUTTON), rsp_valid_ff && (target_ff == cbd_pkg::TGT_NONE) && (fwd_ff == 16'h0000) && !served_ff, "button event result is not empty")
   // Picture register addresses are folded onto eight registers.
   `CBD_ASSERT_NOW(a_pic_fold, rsp_valid_ff && (target_ff == cbd_pkg::TGT_PIC), fwd_ff[15:3] == cbd_pkg::ADDR_PIC_BASE[15:3], "picture register address not folded")

endmodule

>>> design/cbd_decode.sv
// Address decoder: classifies one input item and builds the forwarded address.
// Depends on cbd_pkg.
module cbd_decode #(
   parameter int RAM_DEPTH = 2048
) (
   input  cbd_pkg::req_type req,
   output cbd_pkg::dec_type dec
);

   // RAM index mask: depth mask limited to the mirrored RAM window.
   localparam logic [15:0] RAM_MASK = 16'(RAM_DEPTH - 1) & cbd_pkg::ADDR_RAM_WINDOW;

   // Classify the access against the address map.
   always_comb begin
      logic is_bus;
      logic is_wr;
      is_bus = (req.op == cbd_pkg::OP_READ) || (req.op == cbd_pkg::OP_WRITE);
      is_wr  = (req.op == cbd_pkg::OP_WRITE);

      dec.target    = cbd_pkg::TGT_NONE;
      dec.served    = 1'b0;
      dec.ram_wr    = 1'b0;
      dec.ram_rd    = 1'b0;
      dec.pad_rd    = 1'b0;
      dec.strobe_wr = 1'b0;
      dec.fwd       = 16'h0000;

      if (is_bus) begin
         dec.fwd = req.address;
         if (req.address < cbd_pkg::ADDR_PIC_BASE) begin
            dec.target = cbd_pkg::TGT_RAM;
            dec.served = 1'b1;
            dec.fwd    = req.address & RAM_MASK;
            dec.ram_wr = is_wr;
            dec.ram_rd = !is_wr;
         end else if (req.address <= cbd_pkg::ADDR_PIC_LAST) begin
            dec.target = cbd_pkg::TGT_PIC;
            dec.fwd    = cbd_pkg::ADDR_PIC_BASE | (req.address & cbd_pkg::ADDR_PIC_MASK);
         end else if (req.address == cbd_pkg::ADDR_DMA) begin
            dec.target = cbd_pkg::TGT_DMA;
         end else if ((req.address == cbd_pkg::ADDR_PAD0) ||
                      ((req.address == cbd_pkg::ADDR_PAD1) && !is_wr)) begin
            dec.target    = cbd_pkg::TGT_PAD;
            dec.served    = 1'b1;
            dec.strobe_wr = is_wr;
            dec.pad_rd    = !is_wr;
         end else if (req.address <= cbd_pkg::ADDR_PAD1) begin
            dec.target = cbd_pkg::TGT_AUDIO;
         end else if (req.address < cbd_pkg::ADDR_CART) begin
            dec.target = cbd_pkg::TGT_NONE;
         end else if (req.address < cbd_pkg::ADDR_MAPPER) begin
            dec.target = cbd_pkg::TGT_CART;
         end else begin
            dec.target = cbd_pkg::TGT_MAPPER;
         end
      end
   end

endmodule

>>> design/cbd_ram.sv
// Single-port work RAM with registered read data.
// Depends on nothing beyond its parameter.
module cbd_ram #(
   parameter int RAM_DEPTH = 2048
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(RAM_DEPTH)-1:0] addr,
   input  logic [7:0]                   wr_data,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem_ff [RAM_DEPTH];
   logic [7:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cbd_pads.sv
// Two joypad ports: button latches, serial shift registers and the strobe.
// Depends on cbd_pkg.
module cbd_pads (
   input  logic                 clock,
   input  logic                 reset,
   input  cbd_pkg::pad_ctl_type ctl,
   output logic [7:0]           rd_data
);

   logic       strobe_ff;
   logic       strobe_in;
   logic [7:0] latch_ff [2];
   logic [7:0] latch_in [2];
   logic [7:0] shift_ff [2];
   logic [7:0] shift_in [2];

   // Next state of the latches, shift registers and strobe for one item.
   always_comb begin
      logic [7:0] mask;
      logic [7:0] upd;
      strobe_in = strobe_ff;
      latch_in  = latch_ff;
      shift_in  = shift_ff;
      mask = 8'b0000_0001 << ctl.button_bit;
      upd  = ctl.pressed ? (latch_ff[ctl.port] | mask) : (latch_ff[ctl.port] & ~mask);

      // Button event; with the strobe high the shift register follows the latch.
      if (ctl.btn_en) begin
         latch_in[ctl.port] = upd;
         if (strobe_ff) begin
            shift_in[ctl.port] = upd;
         end
      end

      // Strobe write; a falling strobe loads both shift registers.
      if (ctl.strobe_wr) begin
         if (strobe_ff && !ctl.strobe_data) begin
            shift_in = latch_ff;
         end
         strobe_in = ctl.strobe_data;
      end

      // Serial read with the strobe low shifts a zero in from the top.
      if (ctl.rd_en && !strobe_ff) begin
         shift_in[ctl.port] = shift_ff[ctl.port] >> 1;
      end
   end

   // Read data of the addressed port.
   always_comb begin
      if (strobe_ff) begin
         rd_data = {7'b0, latch_ff[ctl.port][0]};
      end else begin
         rd_data = cbd_pkg::PAD_OPEN_BUS | {7'b0, shift_ff[ctl.port][0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         latch_ff  <= '{default: 8'h00};
         shift_ff  <= '{default: 8'h00};
      end else begin
         strobe_ff <= strobe_in;
         latch_ff  <= latch_in;
         shift_ff  <= shift_in;
      end
   end

endmodule

>>> tb/cbd_result_checker.sv
// Checker for the CPU bus decoder: watches both channels, predicts each result item
// from its own copy of RAM, button latches, shift registers and strobe, and compares.
// Depends on cbd_pkg.
`timescale 1ns / 1ps

module cbd_result_checker #(
   parameter int RAM_DEPTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  cbd_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  cbd_pkg::rsp_type rsp_payload,
   output int               error_count,
   output int               pending_items
);

   // Mirror of the block state.
   logic [7:0] ram_copy [RAM_DEPTH];
   logic [7:0] button_latch [2];
   logic [7:0] pad_shift [2];
   logic       strobe;

   cbd_pkg::rsp_type expected_q [$];
   cbd_pkg::rsp_type want;

   // Applies one access to the mirrored state and returns the result it causes.
   function automatic cbd_pkg::rsp_type predict_access(input cbd_pkg::req_type item);
      cbd_pkg::rsp_type res;
      logic [7:0]       mask;
      logic             port;
      logic             is_write;
      int               idx;
      res.read_data       = 8'h00;
      res.served_inside   = 1'b0;
      res.target          = cbd_pkg::TGT_NONE;
      res.forward_address = 16'h0000;
      is_write = (item.op == cbd_pkg::OP_WRITE);
      case (item.op)
         cbd_pkg::OP_BUTTON: begin
            mask = 8'h01 << item.button_bit;
            if (item.pressed) begin
               button_latch[item.pad_port] = button_latch[item.pad_port] | mask;
            end else begin
               button_latch[item.pad_port] = button_latch[item.pad_port] & ~mask;
            end
            // With the strobe high the shift register follows the latch.
            if (strobe) begin
               pad_shift[item.pad_port] = button_latch[item.pad_port];
            end
         end
         cbd_pkg::OP_READ, cbd_pkg::OP_WRITE: begin
            res.forward_address = item.address;
            if (item.address <= cbd_pkg::ADDR_RAM_WINDOW) begin
               idx = int'(item.address & 16'(RAM_DEPTH - 1) & cbd_pkg::ADDR_RAM_WINDOW);
               res.target          = cbd_pkg::TGT_RAM;
               res.served_inside   = 1'b1;
               res.forward_address = 16'(idx);
               if (is_write) begin
                  ram_copy[idx] = item.write_data;
               end else begin
                  res.read_data = ram_copy[idx];
               end
            end else if (item.address <= cbd_pkg::ADDR_PIC_LAST) begin
               res.target          = cbd_pkg::TGT_PIC;
               res.forward_address = cbd_pkg::ADDR_PIC_BASE +
                                     (item.address & cbd_pkg::ADDR_PIC_MASK);
            end else if (item.address == cbd_pkg::ADDR_DMA) begin
               res.target = cbd_pkg::TGT_DMA;
            end else if (item.address == cbd_pkg::ADDR_PAD0 ||
                         (item.address == cbd_pkg::ADDR_PAD1 && !is_write)) begin
               res.target        = cbd_pkg::TGT_PAD;
               res.served_inside = 1'b1;
               if (is_write) begin
                  // Falling strobe loads both shift registers from their latches.
                  if (strobe && !item.write_data[0]) begin
                     pad_shift[0] = button_latch[0];
                     pad_shift[1] = button_latch[1];
                  end
                  strobe = item.write_data[0];
               end else begin
                  port = (item.address == cbd_pkg::ADDR_PAD1);
                  if (strobe) begin
                     res.read_data = {7'b0, button_latch[port][0]};
                  end else begin
                     res.read_data   = {7'b0, pad_shift[port][0]} | cbd_pkg::PAD_OPEN_BUS;
                     pad_shift[port] = pad_shift[port] >> 1;
                  end
               end
            end else if (item.address <= cbd_pkg::ADDR_PAD1) begin
               res.target = cbd_pkg::TGT_AUDIO;
            end else if (item.address < cbd_pkg::ADDR_CART) begin
               res.target = cbd_pkg::TGT_NONE;
            end else if (item.address < cbd_pkg::ADDR_MAPPER) begin
               res.target = cbd_pkg::TGT_CART;
            end else begin
               res.target = cbd_pkg::TGT_MAPPER;
            end
         end
         default: begin
            // The unused op code changes nothing.
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string field, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         error_count = error_count + 1;
         $display("%0t: %s mismatch, expected %h, actual %h",
                  $time, field, exp_val, act_val);
      end
   endtask

   // Compare a result item first, then predict the item accepted at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         button_latch[0] = 8'h00;
         button_latch[1] = 8'h00;
         pad_shift[0]    = 8'h00;
         pad_shift[1]    = 8'h00;
         strobe          = 1'b0;
         expected_q.delete();
         error_count     = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_payload);
            end else begin
               want = expected_q.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(rsp_payload.read_data));
               check_field("served_inside", 16'(want.served_inside),
                           16'(rsp_payload.served_inside));
               check_field("target", 16'(want.target), 16'(rsp_payload.target));
               check_field("forward_address", want.forward_address,
                           rsp_payload.forward_address);
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(predict_access(req_payload));
         end
      end
      pending_items = expected_q.size();
   end

endmodule

>>> tb/tb_cpu_bus_decoder_with_joypad_ports_unit.sv
// Testbench top for the CPU bus decoder with joypad ports: drives accesses and
// button events with random idling and back-pressure, and gives the verdict.
// Depends on cbd_pkg, the block and cbd_result_checker.
`timescale 1ns / 1ps

module tb_cpu_bus_decoder_with_joypad_ports_unit;

   localparam int         RAM_WORDS      = 2048;
   localparam int         PHASE_ITEMS    = 350;
   localparam int         HOLD_CYCLES    = 40;
   localparam int         DRAIN_CYCLES   = 10;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   logic             clock;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_stall;
   cbd_pkg::req_type req_payload   = '0;
   logic             rsp_valid;
   logic             rsp_stall     = 1'b0;
   cbd_pkg::rsp_type rsp_payload;

   int      error_count;
   int      pending_items;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      items_sent    = 0;
   int      quiet_cycles  = 0;
   logic    long_hold_due = 1'b0;

   // RAM bytes written so far; reads only go to these.
   bit      ram_written [RAM_WORDS];
   int      ram_used [$];

   cpu_bus_decoder_with_joypad_ports_unit #(
      .RAM_DEPTH(RAM_WORDS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   cbd_result_checker #(
      .RAM_DEPTH(RAM_WORDS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .error_count(error_count),
      .pending_items(pending_items)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off per phase counted here.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // A bus access; the button fields carry random noise.
   function automatic cbd_pkg::req_type bus_access(input logic [1:0] op,
                                                   input logic [15:0] address,
                                                   input logic [7:0] data);
      cbd_pkg::req_type item;
      item.op         = op;
      item.address    = address;
      item.write_data = data;
      item.pad_port   = 1'($urandom);
      item.button_bit = 3'($urandom);
      item.pressed    = 1'($urandom);
      return item;
   endfunction

   // A button event; the bus fields carry random noise.
   function automatic cbd_pkg::req_type button_event(input logic port,
                                                     input logic [2:0] bit_pos,
                                                     input logic pressed);
      cbd_pkg::req_type item;
      item            = bus_access(cbd_pkg::OP_BUTTON, 16'($urandom), 8'($urandom));
      item.pad_port   = port;
      item.button_bit = bit_pos;
      item.pressed    = pressed;
      return item;
   endfunction

   // Offers one item after a random gap and returns at the edge that accepts it.
   task automatic send_item(input cbd_pkg::req_type item);
      int idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.op == cbd_pkg::OP_WRITE && item.address <= cbd_pkg::ADDR_RAM_WINDOW) begin
         idx = int'(item.address & 16'(RAM_WORDS - 1));
         if (!ram_written[idx]) begin
            ram_written[idx] = 1'b1;
            ram_used.push_back(idx);
         end
      end
      if (item.op != OP_UNUSED) begin
         items_sent++;
      end
   endtask

   // Well-formed joypad sequence: strobe high, maybe buttons and a read, strobe low, serial reads.
   task automatic pad_burst();
      int n_reads;
      send_item(bus_access(cbd_pkg::OP_WRITE, cbd_pkg::ADDR_PAD0, {7'($urandom), 1'b1}));
      repeat ($urandom_range(2)) begin
         send_item(button_event(1'($urandom), 3'($urandom), 1'($urandom)));
      end
      if ($urandom_range(3) == 0) begin
         send_item(bus_access(cbd_pkg::OP_READ,
                              $urandom_range(1) ? cbd_pkg::ADDR_PAD1 : cbd_pkg::ADDR_PAD0,
                              8'($urandom)));
      end
      send_item(bus_access(cbd_pkg::OP_WRITE, cbd_pkg::ADDR_PAD0, {7'($urandom), 1'b0}));
      n_reads = $urandom_range(10, 6);
      repeat (n_reads) begin
         send_item(bus_access(cbd_pkg::OP_READ,
                              $urandom_range(1) ? cbd_pkg::ADDR_PAD1 : cbd_pkg::ADDR_PAD0,
                              8'($urandom)));
      end
   endtask

   task automatic random_item();
      int               pick;
      int               k;
      logic [15:0]      addr;
      logic [1:0]       op;
      cbd_pkg::req_type item;
      pick = $urandom_range(99);
      if (pick < 25) begin
         send_item(bus_access(cbd_pkg::OP_WRITE, 16'($urandom_range(16'h1FFF)),
                              8'($urandom)));
      end else if (pick < 45 && ram_used.size() != 0) begin
         // Read back a written byte through any of its mirrors.
         k    = $urandom_range(ram_used.size() - 1);
         addr = 16'(ram_used[k]) | 16'($urandom_range(3) << 11);
         send_item(bus_access(cbd_pkg::OP_READ, addr, 8'($urandom)));
      end else if (pick < 57) begin
         send_item(button_event(1'($urandom), 3'($urandom), 1'($urandom)));
      end else if (pick < 80) begin
         pad_burst();
      end else if (pick < 97) begin
         addr = ($urandom_range(3) == 0) ? 16'(16'h4014 + $urandom_range(3))
                                         : 16'($urandom);
         op   = $urandom_range(1) ? cbd_pkg::OP_WRITE : cbd_pkg::OP_READ;
         if (op == cbd_pkg::OP_READ && addr <= cbd_pkg::ADDR_RAM_WINDOW &&
             !ram_written[int'(addr & 16'(RAM_WORDS - 1))]) begin
            op = cbd_pkg::OP_WRITE;
         end
         send_item(bus_access(op, addr, 8'($urandom)));
      end else begin
         item    = bus_access(cbd_pkg::OP_READ, 16'($urandom), 8'($urandom));
         item.op = OP_UNUSED;
         send_item(item);
      end
   endtask

   // Main stimulus: reset, directed items, then three phases of random items.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            // RAM extremes and mirrors.
            send_item(bus_access(cbd_pkg::OP_WRITE, 16'h0000, 8'h00));
            send_item(bus_access(cbd_pkg::OP_WRITE, 16'h1FFF, 8'hFF));
            send_item(bus_access(cbd_pkg::OP_READ, 16'h0800, 8'h00));
            send_item(bus_access(cbd_pkg::OP_READ, 16'h17FF, 8'hFF));
            // Every region of the address map, both edges where they matter.
            send_item(bus_access(cbd_pkg::OP_READ, 16'h2000, 8'h00));
            send_item(bus_access(cbd_pkg::OP_WRITE, 16'h3FFF, 8'h5A));
            send_item(bus_access(cbd_pkg::OP_READ, 16'h4013, 8'h00));
            send_item(bus_access(cbd_pkg::OP_WRITE, cbd_pkg::ADDR_DMA, 8'h02));
            send_item(bus_access(cbd_pkg::OP_READ, 16'h4015, 8'h00));
            // A write to the second joypad address goes to audio.
            send_item(bus_access(cbd_pkg::OP_WRITE, cbd_pkg::ADDR_PAD1, 8'hFF));
            send_item(bus_access(cbd_pkg::OP_READ, 16'h4018, 8'h00));
            send_item(bus_access(cbd_pkg::OP_READ, cbd_pkg::ADDR_CART, 8'h00));
            send_item(bus_access(cbd_pkg::OP_WRITE, 16'hFFFF, 8'hC3));
            // Button events, then an item with the unused op code.
            send_item(button_event(1'b0, 3'd0, 1'b1));
            send_item(button_event(1'b1, 3'd7, 1'b1));
            begin : req_payload_unused
               cbd_pkg::req_type item;
               item    = bus_access(cbd_pkg::OP_READ, 16'h4016, 8'hFF);
               item.op = OP_UNUSED;
               send_item(item);
            end
            // Strobe high: reads return latch bit 0 and a button event reloads.
            send_item(bus_access(cbd_pkg::OP_WRITE, cbd_pkg::ADDR_PAD0, 8'h01));
            send_item(bus_access(cbd_pkg::OP_READ, cbd_pkg::ADDR_PAD0, 8'h00));
            send_item(button_event(1'b1, 3'd0, 1'b1));
            send_item(bus_access(cbd_pkg::OP_READ, cbd_pkg::ADDR_PAD1, 8'h00));
            // Falling strobe loads the shift registers; serial reads follow.
            send_item(bus_access(cbd_pkg::OP_WRITE, cbd_pkg::ADDR_PAD0, 8'hFE));
            send_item(bus_access(cbd_pkg::OP_READ, cbd_pkg::ADDR_PAD0, 8'h00));
            send_item(bus_access(cbd_pkg::OP_READ, cbd_pkg::ADDR_PAD0, 8'h00));
            send_item(bus_access(cbd_pkg::OP_READ, cbd_pkg::ADDR_PAD1, 8'h00));
            send_item(button_event(1'b0, 3'd0, 1'b0));
         end

         // Long receiver hold-off while the sender keeps offering items.
         long_hold_due = 1'b1;
         begin
            int phase_end;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) random_item();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_items != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/cbd_pkg.sv
design/cbd_decode.sv
design/cbd_ram.sv
design/cbd_pads.sv
design/cpu_bus_decoder_with_joypad_ports_unit.sv
tb/cbd_result_checker.sv
tb/tb_cpu_bus_decoder_with_joypad_ports_unit.sv
